FILE: hdl/fpod_pkg.sv
// ----------------------------------------------------------------------------
// fpod_pkg
// Shared codes, types and helpers for the four-position off-delay timer.
// ----------------------------------------------------------------------------
package fpod_pkg;

   localparam int PosWidth    = 3;
   localparam int TimeWidth   = 32;
   localparam int PresetWidth = 31;
   localparam int CsrIdxWidth = 2;

   // switch position codes
   localparam logic [PosWidth-1:0] POS_OFF        = 3'd0;
   localparam logic [PosWidth-1:0] POS_MOM_FWD    = 3'd1;
   localparam logic [PosWidth-1:0] POS_MOM_BACK   = 3'd2;
   localparam logic [PosWidth-1:0] POS_MOM_FLOAT  = 3'd3;
   localparam logic [PosWidth-1:0] POS_HELD_FWD   = 3'd4;
   localparam logic [PosWidth-1:0] POS_HELD_BACK  = 3'd5;
   localparam logic [PosWidth-1:0] POS_HELD_FLOAT = 3'd6;
   localparam logic [PosWidth-1:0] POS_INVALID    = 3'd7;

   // register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_PRESET_UP    = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_PRESET_DOWN  = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_PRESET_FLOAT = 2'd2;

   typedef struct packed {
      logic [PresetWidth-1:0] up;
      logic [PresetWidth-1:0] down;
      logic [PresetWidth-1:0] flt;
   } presets_type;

   typedef struct packed {
      logic [PosWidth-1:0]         position;
      logic signed [TimeWidth-1:0] elapsed;
      logic                        cleared;
   } result_type;

   // signed elapsed time has reached a non-negative preset
   function automatic logic reached(input logic [TimeWidth-1:0] elapsed,
                                    input logic [PresetWidth-1:0] preset);
      reached = !elapsed[TimeWidth-1] && (elapsed[PresetWidth-1:0] >= preset);
   endfunction

endpackage

FILE: hdl/fpod_presets.sv
// ----------------------------------------------------------------------------
// fpod_presets
// Off-delay preset registers, one per switch direction.
// ----------------------------------------------------------------------------
module fpod_presets (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [fpod_pkg::CsrIdxWidth-1:0]    csr_index,
   input  logic [fpod_pkg::PresetWidth-1:0]    csr_data,
   output fpod_pkg::presets_type               presets
);

   fpod_pkg::presets_type presets_ff;
   fpod_pkg::presets_type presets_in;

   always_comb begin
      presets_in = presets_ff;
      if (csr_write) begin
         unique case (csr_index)
            fpod_pkg::CSR_PRESET_UP:    presets_in.up   = csr_data;
            fpod_pkg::CSR_PRESET_DOWN:  presets_in.down = csr_data;
            fpod_pkg::CSR_PRESET_FLOAT: presets_in.flt  = csr_data;
            default:                    presets_in      = presets_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         presets_ff <= '0;
      end else begin
         presets_ff <= presets_in;
      end
   end

   assign presets = presets_ff;

endmodule

FILE: hdl/fpod_timer.sv
// ----------------------------------------------------------------------------
// fpod_timer
// Latched position and start time, with the next-state decision for one
// request.
// ----------------------------------------------------------------------------
module fpod_timer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              fire,
   input  logic [fpod_pkg::PosWidth-1:0]     position,
   input  logic [fpod_pkg::TimeWidth-1:0]    now_ms,
   input  fpod_pkg::presets_type             presets,
   output fpod_pkg::result_type              result
);

   logic [fpod_pkg::PosWidth-1:0]  latched_ff;
   logic [fpod_pkg::PosWidth-1:0]  latched_in;
   logic [fpod_pkg::TimeWidth-1:0] start_ff;
   logic [fpod_pkg::TimeWidth-1:0] start_in;
   logic [fpod_pkg::TimeWidth-1:0] elapsed;
   logic                           cleared;

   assign elapsed = now_ms - start_ff;

   always_comb begin
      latched_in = latched_ff;
      start_in   = start_ff;
      cleared    = 1'b0;
      unique case (position)
         fpod_pkg::POS_OFF: begin
            unique case (latched_ff)
               fpod_pkg::POS_MOM_FWD, fpod_pkg::POS_HELD_FWD: begin
                  if (fpod_pkg::reached(elapsed, presets.up)) latched_in = fpod_pkg::POS_OFF;
               end
               fpod_pkg::POS_MOM_BACK, fpod_pkg::POS_HELD_BACK: begin
                  if (fpod_pkg::reached(elapsed, presets.down)) latched_in = fpod_pkg::POS_OFF;
               end
               fpod_pkg::POS_MOM_FLOAT, fpod_pkg::POS_HELD_FLOAT: begin
                  if (fpod_pkg::reached(elapsed, presets.flt)) latched_in = fpod_pkg::POS_OFF;
               end
               default: latched_in = fpod_pkg::POS_OFF;
            endcase
         end
         fpod_pkg::POS_MOM_FWD, fpod_pkg::POS_MOM_BACK, fpod_pkg::POS_MOM_FLOAT: begin
            // press while active cancels, press while off starts the timer
            if (latched_ff != fpod_pkg::POS_OFF) begin
               latched_in = fpod_pkg::POS_OFF;
               cleared    = 1'b1;
            end else begin
               latched_in = position;
               start_in   = now_ms;
            end
         end
         fpod_pkg::POS_HELD_FWD, fpod_pkg::POS_HELD_BACK, fpod_pkg::POS_HELD_FLOAT: begin
            if (latched_ff == position - 3'd3) latched_in = position;
         end
         default: begin
            latched_in = fpod_pkg::POS_OFF;
            cleared    = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latched_ff <= fpod_pkg::POS_OFF;
         start_ff   <= '0;
      end else if (fire) begin
         latched_ff <= latched_in;
         start_ff   <= start_in;
      end
   end

   assign result.position = latched_in;
   assign result.elapsed  = elapsed;
   assign result.cleared  = cleared;

   a_invalid_drops: assert property (@(posedge clock) disable iff (reset)
      fire && position == fpod_pkg::POS_INVALID |=> latched_ff == fpod_pkg::POS_OFF)
      else $error("invalid position did not drop the output");

   a_cleared_is_off: assert property (@(posedge clock) disable iff (reset)
      cleared |-> latched_in == fpod_pkg::POS_OFF)
      else $error("cleared command left an active output");

   a_start_holds: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(start_ff) && $stable(latched_ff))
      else $error("timer state changed without a request");

endmodule

FILE: hdl/four_position_three_preset_off_delay.sv
// ----------------------------------------------------------------------------
// four_position_three_preset_off_delay
// Off-delay timer for a four-position switch with one preset per direction.
// ----------------------------------------------------------------------------
// Path: a request passes the request register, then the result register.
// Throughput: one request per cycle while the result side does not stall;
//   the timer decision is a single pass of one 32-bit subtract and a
//   preset compare.
// Reset: synchronous; clears presets to 0, latched position to Off, start
//   time to 0 and both pipeline valids.
module four_position_three_preset_off_delay (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write,
   input  logic [fpod_pkg::CsrIdxWidth-1:0]       csr_index,
   input  logic [fpod_pkg::PresetWidth-1:0]       csr_data,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [fpod_pkg::PosWidth-1:0]          req_position,
   input  logic [fpod_pkg::TimeWidth-1:0]         req_now_ms,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [fpod_pkg::PosWidth-1:0]          rsp_active_position,
   output logic signed [fpod_pkg::TimeWidth-1:0]  rsp_elapsed_ms,
   output logic                                   rsp_command_cleared
);

   fpod_pkg::presets_type presets;
   fpod_pkg::result_type  result;

   logic                           req_valid_ff;
   logic                           req_valid_in;
   logic [fpod_pkg::PosWidth-1:0]  req_position_ff;
   logic [fpod_pkg::TimeWidth-1:0] req_now_ff;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   fpod_pkg::result_type           rsp_ff;
   logic                           out_ready;
   logic                           fire;

   assign out_ready    = !rsp_valid_ff || !rsp_stall;
   assign fire         = req_valid_ff && out_ready;
   assign req_stall    = req_valid_ff && !out_ready;
   assign req_valid_in = req_stall ? req_valid_ff : req_valid;
   assign rsp_valid_in = out_ready ? req_valid_ff : rsp_valid_ff;

   fpod_presets u_presets (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .presets   (presets)
   );

   fpod_timer u_timer (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .position (req_position_ff),
      .now_ms   (req_now_ff),
      .presets  (presets),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the request register while the result side is stalled
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         req_position_ff <= req_position;
         req_now_ff      <= req_now_ms;
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_active_position = rsp_ff.position;
   assign rsp_elapsed_ms      = rsp_ff.elapsed;
   assign rsp_command_cleared = rsp_ff.cleared;

endmodule

FILE: sim/four_position_three_preset_off_delay_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// four_position_three_preset_off_delay_test
// Self-checking bench for the four-position off-delay timer. A directed
// table covers reset state, time extremes, cancels, invalid input and
// preset limits. Random phases follow, each with its own presets, pacing
// and time base, and mostly press / hold / release sequences. Each result
// is checked against a typed row value or an in-bench timer predictor.
// ----------------------------------------------------------------------------
module four_position_three_preset_off_delay_test;

   localparam int MAX_IDLE      = 18;
   localparam int HOLD_CYCLES   = 200;
   localparam int SETTLE_CYCLES = 4;
   localparam int DIRECTED_ROWS = 25;
   localparam int PRESET_ROW    = 19;
   localparam int RANDOM_PHASES = 7;
   localparam int PHASE_ITEMS   = 150;
   localparam int REPORT_LIMIT  = 10;
   localparam logic [fpod_pkg::CsrIdxWidth-1:0] CSR_SPARE   = 2'd3;
   localparam logic [fpod_pkg::PresetWidth-1:0] PRESET_MAX  = 31'h7FFF_FFFF;
   localparam logic [fpod_pkg::PosWidth-1:0]    HELD_OFFSET =
      fpod_pkg::POS_HELD_FWD - fpod_pkg::POS_MOM_FWD;

   typedef enum int {PACE_STEADY, PACE_BURSTY, PACE_SLOW} pace_type;

   typedef struct packed {
      logic [fpod_pkg::PosWidth-1:0]  pos;
      logic [fpod_pkg::TimeWidth-1:0] now;
      logic                           typed;
      fpod_pkg::result_type           want;
   } directed_step_type;

   logic                                  clock = 1'b0;
   logic                                  reset;
   logic                                  csr_write;
   logic [fpod_pkg::CsrIdxWidth-1:0]      csr_index;
   logic [fpod_pkg::PresetWidth-1:0]      csr_data;
   logic                                  req_valid;
   logic                                  req_stall;
   logic [fpod_pkg::PosWidth-1:0]         req_position;
   logic [fpod_pkg::TimeWidth-1:0]        req_now_ms;
   logic                                  rsp_valid;
   logic                                  rsp_stall;
   logic [fpod_pkg::PosWidth-1:0]         rsp_active_position;
   logic signed [fpod_pkg::TimeWidth-1:0] rsp_elapsed_ms;
   logic                                  rsp_command_cleared;

   // timer predictor state
   logic [fpod_pkg::PosWidth-1:0]    latched_pos  = fpod_pkg::POS_OFF;
   logic [fpod_pkg::TimeWidth-1:0]   start_ms     = '0;
   logic [fpod_pkg::PresetWidth-1:0] up_preset    = '0;
   logic [fpod_pkg::PresetWidth-1:0] down_preset  = '0;
   logic [fpod_pkg::PresetWidth-1:0] float_preset = '0;

   fpod_pkg::result_type           pending_results[$];
   fpod_pkg::result_type           typed_result;
   bit                             typed_pending  = 1'b0;
   bit                             hold_request   = 1'b0;
   pace_type                       sender_pace    = PACE_STEADY;
   pace_type                       receiver_pace  = PACE_STEADY;
   int                             requests_sent  = 0;
   int                             mismatch_count = 0;
   int unsigned                    step_span      = 150;
   logic [fpod_pkg::TimeWidth-1:0] wall_ms        = '0;

   directed_step_type script [DIRECTED_ROWS] = '{
      // presets all zero after reset
      '{fpod_pkg::POS_OFF, 32'h0000_0000, 1'b1,
        '{fpod_pkg::POS_OFF, 32'h0000_0000, 1'b0}},
      '{fpod_pkg::POS_INVALID, 32'hFFFF_FFFF, 1'b1,
        '{fpod_pkg::POS_OFF, 32'hFFFF_FFFF, 1'b1}},
      '{fpod_pkg::POS_HELD_FWD, 32'h0000_0005, 1'b1,
        '{fpod_pkg::POS_OFF, 32'h0000_0005, 1'b0}},
      '{fpod_pkg::POS_MOM_FWD, 32'h0000_0064, 1'b1,
        '{fpod_pkg::POS_MOM_FWD, 32'h0000_0064, 1'b0}},
      '{fpod_pkg::POS_HELD_FWD, 32'h0000_0065, 1'b1,
        '{fpod_pkg::POS_HELD_FWD, 32'h0000_0001, 1'b0}},
      '{fpod_pkg::POS_HELD_BACK, 32'h0000_0066, 1'b0, '0},
      '{fpod_pkg::POS_OFF, 32'h0000_0064, 1'b1,
        '{fpod_pkg::POS_OFF, 32'h0000_0000, 1'b0}},
      '{fpod_pkg::POS_MOM_BACK, 32'h8000_0000, 1'b0, '0},
      '{fpod_pkg::POS_OFF, 32'h0000_0000, 1'b1,
        '{fpod_pkg::POS_MOM_BACK, 32'h8000_0000, 1'b0}},
      '{fpod_pkg::POS_MOM_FLOAT, 32'h0000_0007, 1'b1,
        '{fpod_pkg::POS_OFF, 32'h8000_0007, 1'b1}},
      '{fpod_pkg::POS_MOM_FLOAT, 32'h7FFF_FFFF, 1'b0, '0},
      '{fpod_pkg::POS_HELD_FLOAT, 32'h8000_0000, 1'b0, '0},
      '{fpod_pkg::POS_OFF, 32'hFFFF_FFFE, 1'b1,
        '{fpod_pkg::POS_OFF, 32'h7FFF_FFFF, 1'b0}},
      '{fpod_pkg::POS_OFF, 32'h0000_0000, 1'b0, '0},
      '{fpod_pkg::POS_MOM_BACK, 32'h0000_03E8, 1'b0, '0},
      '{fpod_pkg::POS_HELD_BACK, 32'h0000_03E9, 1'b0, '0},
      '{fpod_pkg::POS_INVALID, 32'h0000_03EA, 1'b0, '0},
      '{fpod_pkg::POS_MOM_FWD, 32'h0000_0032, 1'b0, '0},
      '{fpod_pkg::POS_MOM_FWD, 32'h0000_003C, 1'b0, '0},
      // up preset at maximum, down zero, float 1000
      '{fpod_pkg::POS_MOM_FWD, 32'h0000_0000, 1'b0, '0},
      '{fpod_pkg::POS_OFF, 32'h7FFF_FFFE, 1'b0, '0},
      '{fpod_pkg::POS_OFF, 32'h7FFF_FFFF, 1'b1,
        '{fpod_pkg::POS_OFF, 32'h7FFF_FFFF, 1'b0}},
      '{fpod_pkg::POS_MOM_FLOAT, 32'h0000_000A, 1'b0, '0},
      '{fpod_pkg::POS_OFF, 32'h0000_03F1, 1'b0, '0},
      '{fpod_pkg::POS_OFF, 32'h0000_03F2, 1'b0, '0}
   };

   four_position_three_preset_off_delay u_top (
      .clock               (clock),
      .reset               (reset),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_position        (req_position),
      .req_now_ms          (req_now_ms),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_active_position (rsp_active_position),
      .rsp_elapsed_ms      (rsp_elapsed_ms),
      .rsp_command_cleared (rsp_command_cleared)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #10ms;
      $display("[four_position_three_preset_off_delay] ERROR");
      $finish;
   end

   // advance the timer by one request and return the result it produces
   function automatic fpod_pkg::result_type advance_timer(
         input logic [fpod_pkg::PosWidth-1:0]  pos,
         input logic [fpod_pkg::TimeWidth-1:0] now);
      fpod_pkg::result_type             res;
      logic [fpod_pkg::TimeWidth-1:0]   elapsed;
      logic [fpod_pkg::PresetWidth-1:0] limit;
      elapsed     = now - start_ms;
      res.cleared = 1'b0;
      case (pos)
         fpod_pkg::POS_OFF: begin
            case (latched_pos)
               fpod_pkg::POS_MOM_FWD, fpod_pkg::POS_HELD_FWD:     limit = up_preset;
               fpod_pkg::POS_MOM_BACK, fpod_pkg::POS_HELD_BACK:   limit = down_preset;
               fpod_pkg::POS_MOM_FLOAT, fpod_pkg::POS_HELD_FLOAT: limit = float_preset;
               default:                                           limit = '0;
            endcase
            // negative elapsed never reaches a preset
            if (latched_pos == fpod_pkg::POS_OFF ||
                (!elapsed[fpod_pkg::TimeWidth-1] && elapsed >= {1'b0, limit}))
               latched_pos = fpod_pkg::POS_OFF;
         end
         fpod_pkg::POS_MOM_FWD, fpod_pkg::POS_MOM_BACK, fpod_pkg::POS_MOM_FLOAT: begin
            if (latched_pos != fpod_pkg::POS_OFF) begin
               latched_pos = fpod_pkg::POS_OFF;
               res.cleared = 1'b1;
            end else begin
               start_ms    = now;
               latched_pos = pos;
            end
         end
         fpod_pkg::POS_HELD_FWD, fpod_pkg::POS_HELD_BACK, fpod_pkg::POS_HELD_FLOAT: begin
            if (latched_pos == pos - HELD_OFFSET)
               latched_pos = pos;
         end
         default: begin
            latched_pos = fpod_pkg::POS_OFF;
            res.cleared = 1'b1;
         end
      endcase
      res.position = latched_pos;
      res.elapsed  = elapsed;
      return res;
   endfunction

   function automatic int idle_cycles(input pace_type pace);
      case (pace)
         PACE_STEADY: return 0;
         PACE_BURSTY: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_IDLE) : 0;
         default:     return $urandom_range(0, MAX_IDLE);
      endcase
   endfunction

   // mostly move time forward, now and then step back to get negative elapsed
   function automatic logic [fpod_pkg::TimeWidth-1:0] tick_wall();
      if ($urandom_range(0, 39) == 0)
         wall_ms = wall_ms - 32'($urandom_range(1, 1000));
      else
         wall_ms = wall_ms + 32'($urandom_range(0, step_span));
      return wall_ms;
   endfunction

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t: %s", $realtime, msg);
   endtask

   // called at a falling edge, returns at the falling edge after the accept
   task automatic offer_request(input logic [fpod_pkg::PosWidth-1:0]  pos,
                                input logic [fpod_pkg::TimeWidth-1:0] now);
      int                   gap;
      fpod_pkg::result_type predicted;
      gap = idle_cycles(sender_pace);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_position <= pos;
      req_now_ms   <= now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = advance_timer(pos, now);
      pending_results.push_back(typed_pending ? typed_result : predicted);
      typed_pending = 1'b0;
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic load_presets(input logic [fpod_pkg::PresetWidth-1:0] up,
                               input logic [fpod_pkg::PresetWidth-1:0] down,
                               input logic [fpod_pkg::PresetWidth-1:0] flt);
      csr_write <= 1'b1;
      csr_index <= fpod_pkg::CSR_PRESET_UP;
      csr_data  <= up;
      @(negedge clock);
      csr_index <= fpod_pkg::CSR_PRESET_DOWN;
      csr_data  <= down;
      @(negedge clock);
      csr_index <= fpod_pkg::CSR_PRESET_FLOAT;
      csr_data  <= flt;
      @(negedge clock);
      // unused index, must be dropped
      csr_index <= CSR_SPARE;
      csr_data  <= 31'($urandom());
      @(negedge clock);
      csr_write    <= 1'b0;
      up_preset    = up;
      down_preset  = down;
      float_preset = flt;
   endtask

   // one press with an optional follow-up, then one to six releases; or one random request
   task automatic run_press_sequence();
      logic [fpod_pkg::PosWidth-1:0] dir;
      int                            off_steps;
      dir       = 3'($urandom_range(fpod_pkg::POS_MOM_FWD, fpod_pkg::POS_MOM_FLOAT));
      off_steps = $urandom_range(1, 6);
      if ($urandom_range(0, 9) < 2) begin
         offer_request(3'($urandom_range(0, 7)), $urandom());
         return;
      end
      offer_request(dir, tick_wall());
      case ($urandom_range(0, 9))
         0, 1, 2, 3: offer_request(dir + HELD_OFFSET, tick_wall());
         4: offer_request(3'($urandom_range(fpod_pkg::POS_HELD_FWD, fpod_pkg::POS_HELD_FLOAT)),
                          tick_wall());
         5: offer_request(3'($urandom_range(fpod_pkg::POS_MOM_FWD, fpod_pkg::POS_MOM_FLOAT)),
                          tick_wall());
         6: offer_request(fpod_pkg::POS_INVALID, tick_wall());
         default: ;
      endcase
      repeat (off_steps) offer_request(fpod_pkg::POS_OFF, tick_wall());
   endtask

   initial begin
      int first;
      reset        <= 1'b1;
      csr_write    <= 1'b0;
      csr_index    <= fpod_pkg::CSR_PRESET_UP;
      csr_data     <= '0;
      req_valid    <= 1'b0;
      req_position <= fpod_pkg::POS_OFF;
      req_now_ms   <= '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      sender_pace   = pace_type'($urandom_range(PACE_STEADY, PACE_SLOW));
      receiver_pace = pace_type'($urandom_range(PACE_STEADY, PACE_SLOW));
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (i == PRESET_ROW) begin
            wait_idle();
            load_presets(PRESET_MAX, '0, 31'd1000);
         end
         typed_pending = script[i].typed;
         typed_result  = script[i].want;
         offer_request(script[i].pos, script[i].now);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         first         = requests_sent;
         sender_pace   = pace_type'($urandom_range(PACE_STEADY, PACE_SLOW));
         receiver_pace = pace_type'($urandom_range(PACE_STEADY, PACE_SLOW));
         step_span     = 150;
         wall_ms       = $urandom();
         case (phase)
            0: begin
               sender_pace   = PACE_STEADY;
               receiver_pace = PACE_STEADY;
               load_presets(31'($urandom_range(0, 300)), 31'($urandom_range(0, 300)),
                            31'($urandom_range(0, 300)));
            end
            1: load_presets(PRESET_MAX, '0, 31'($urandom_range(0, 300)));
            2: begin
               // keep feeding while the result side holds off
               sender_pace  = PACE_STEADY;
               hold_request = 1'b1;
               load_presets(31'($urandom_range(0, 300)), 31'($urandom_range(0, 300)),
                            31'($urandom_range(0, 300)));
            end
            3: begin
               wall_ms = 32'hFFFF_FC00;
               load_presets(31'($urandom_range(0, 300)), 31'($urandom_range(0, 300)),
                            31'($urandom_range(0, 300)));
            end
            4: load_presets('0, PRESET_MAX, '0);
            5: begin
               step_span = 32'hFFFF_FFFF;
               load_presets(31'($urandom()), 31'($urandom()), 31'($urandom()));
            end
            default: load_presets(31'($urandom_range(0, 300)), 31'($urandom_range(0, 300)),
                                  31'($urandom_range(0, 300)));
         endcase
         while (requests_sent - first < PHASE_ITEMS) run_press_sequence();
      end

      wait_idle();
      if (mismatch_count == 0)
         $display("[four_position_three_preset_off_delay] OK");
      else
         $display("[four_position_three_preset_off_delay] ERROR");
      $finish;
   end

   // result side pacing
   initial begin
      int gap;
      rsp_stall <= 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         gap = idle_cycles(receiver_pace);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      fpod_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            flag_mismatch($sformatf("unexpected result: pos %0d elapsed %0d cleared %0d",
                                    rsp_active_position, rsp_elapsed_ms,
                                    rsp_command_cleared));
         end else begin
            want = pending_results.pop_front();
            if (rsp_active_position !== want.position ||
                rsp_elapsed_ms !== want.elapsed ||
                rsp_command_cleared !== want.cleared)
               flag_mismatch($sformatf({"result mismatch: expected pos %0d elapsed %0d ",
                                        "cleared %0d, got pos %0d elapsed %0d cleared %0d"},
                                       want.position, $signed(want.elapsed), want.cleared,
                                       rsp_active_position, rsp_elapsed_ms,
                                       rsp_command_cleared));
         end
      end
   end

endmodule

FILE: sim.f
hdl/fpod_pkg.sv
hdl/fpod_presets.sv
hdl/fpod_timer.sv
hdl/four_position_three_preset_off_delay.sv
sim/four_position_three_preset_off_delay_test.sv
